[hdl/scr_pkg.sv]
// ============================================================================
// scr_pkg: shared definitions for the sketch command rasterizer
// Command opcodes, tool codes, grey conversion constants and the status
// record passed from the grey conversion unit to the sequencer.
// ============================================================================
package scr_pkg;

    // Opcodes in bits 7-6 of a command byte.
    localparam logic [1:0] OP_DX   = 2'd0;
    localparam logic [1:0] OP_DY   = 2'd1;
    localparam logic [1:0] OP_TOOL = 2'd2;
    localparam logic [1:0] OP_DATA = 2'd3;

    // Tool selection codes as held in the tool register.
    localparam logic [1:0] TOOL_NONE  = 2'd0;
    localparam logic [1:0] TOOL_LINE  = 2'd1;
    localparam logic [1:0] TOOL_BLOCK = 2'd2;

    // Operand codes of the TOOL command (raw 6-bit operand field).
    localparam logic [5:0] TSEL_NONE    = 6'd0;
    localparam logic [5:0] TSEL_LINE    = 6'd1;
    localparam logic [5:0] TSEL_BLOCK   = 6'd2;
    localparam logic [5:0] TSEL_COLOUR  = 6'd3;
    localparam logic [5:0] TSEL_TARGETX = 6'd4;
    localparam logic [5:0] TSEL_TARGETY = 6'd5;

    // Grey = (299 R + 587 G + 114 B + 500) / 1000. The division is done as a
    // multiplication by ceil(2^28 / 1000) followed by a 28-bit shift, which is
    // exact for every sum below 2^18.
    localparam int         SUM_W       = 18;
    localparam int         RECIP_W     = 19;
    localparam int         PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] WEIGHT_R    = 19'd299;
    localparam logic [RECIP_W-1:0] WEIGHT_G    = 19'd587;
    localparam logic [RECIP_W-1:0] WEIGHT_B    = 19'd114;
    localparam logic [SUM_W-1:0]   GREY_ROUND  = 18'd500;
    localparam logic [RECIP_W-1:0] GREY_RECIP  = 19'd268436;
    localparam int                 GREY_SHIFT  = 28;

    // Status from the grey conversion unit.
    typedef struct packed {
        logic       done;
        logic [7:0] value;
    } grey_stat_t;

endpackage

[hdl/scr_req_if.sv]
// ============================================================================
// scr_req_if: request channel of the sketch command rasterizer
// Carries one command or pixel read per transaction with valid/ready.
// ============================================================================
interface scr_req_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] code_byte;
    logic [7:0] read_col;
    logic [7:0] read_row;

    modport source (output valid, output cmd, output code_byte, output read_col,
                    output read_row, input ready);
    modport sink   (input valid, input cmd, input code_byte, input read_col,
                    input read_row, output ready);
endinterface

[hdl/scr_rsp_if.sv]
// ============================================================================
// scr_rsp_if: response channel of the sketch command rasterizer
// Carries one result per transaction with valid/ready.
// ============================================================================
interface scr_rsp_if;
    logic              valid;
    logic              ready;
    logic [7:0]        pixel_value;
    logic signed [15:0] pen_col;
    logic signed [15:0] pen_row;
    logic [1:0]        active_tool;

    modport source (output valid, output pixel_value, output pen_col,
                    output pen_row, output active_tool, input ready);
    modport sink   (input valid, input pixel_value, input pen_col,
                    input pen_row, input active_tool, output ready);
endinterface

[hdl/sketch_command_rasterizer.sv]
// ============================================================================
// sketch_command_rasterizer: sketch command interpreter with grey frame store
// Pen moves, targets, data and tool commands go from idle to delivery; a colour
// set waits on the six-step grey conversion multiplier before delivery.
// A pixel read passes address and memory states and the registered read port.
// A block fill passes setup and base states, then writes one pixel per cycle
// through the one write port. After reset the whole frame store is cleared,
// during which no transaction is accepted. One transaction is in work at a time.
// ============================================================================
module sketch_command_rasterizer #(
    parameter int FRAME_SIZE = 200
) (
    input  logic      clk,
    input  logic      rst_n,
    scr_req_if.sink   req,
    scr_rsp_if.source rsp
);
    import scr_pkg::*;

    localparam int ADDR_W = $clog2(FRAME_SIZE * FRAME_SIZE);
    localparam int CNT_W  = $clog2(FRAME_SIZE + 1);
    localparam logic [ADDR_W-1:0]     FS_A      = ADDR_W'(FRAME_SIZE);
    localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(FRAME_SIZE * FRAME_SIZE - 1);
    localparam logic signed [15:0]    FS_S      = 16'(FRAME_SIZE);
    localparam logic [8:0]            FS_9      = 9'(FRAME_SIZE);
    localparam logic [CNT_W-1:0]      FS_C      = CNT_W'(FRAME_SIZE);

    localparam logic [3:0] ST_CLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_GREY    = 4'd2;
    localparam logic [3:0] ST_FSETUP  = 4'd3;
    localparam logic [3:0] ST_FBASE   = 4'd4;
    localparam logic [3:0] ST_FILL    = 4'd5;
    localparam logic [3:0] ST_RADDR   = 4'd6;
    localparam logic [3:0] ST_RMEM    = 4'd7;
    localparam logic [3:0] ST_DELIVER = 4'd8;

    // Clamp a signed coordinate to the range 0..FRAME_SIZE.
    function automatic logic [CNT_W-1:0] clamp_frame(input logic signed [15:0] v);
        logic [CNT_W-1:0] res;
        if (v < 16'sd0)
            res = '0;
        else if (v > FS_S)
            res = FS_C;
        else
            res = v[CNT_W-1:0];
        return res;
    endfunction

    // Architectural state.
    logic [3:0]         state_reg, state_next;
    logic signed [15:0] pen_x_reg, pen_x_next;
    logic signed [15:0] pen_y_reg, pen_y_next;
    logic signed [15:0] tx_reg, tx_next;
    logic signed [15:0] ty_reg, ty_next;
    logic [7:0]         grey_reg, grey_next;
    logic [31:0]        acc_reg, acc_next;
    logic [1:0]         tool_reg, tool_next;

    // Sequencer working registers.
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0]   row_reg, row_next;
    logic [CNT_W-1:0]   col_reg, col_next;
    logic [CNT_W-1:0]   c0_reg, c0_next;
    logic [CNT_W-1:0]   r1_reg, r1_next;
    logic [CNT_W-1:0]   c1_reg, c1_next;
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [7:0]         rd_row_reg, rd_row_next;
    logic [7:0]         rd_col_reg, rd_col_next;
    logic               rd_ok_reg, rd_ok_next;
    logic               is_read_reg, is_read_next;
    logic [ADDR_W-1:0]  rd_addr_reg, rd_addr_next;
    logic [7:0]         rd_data_reg;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_pix_reg, out_pix_next;
    logic signed [15:0] out_col_reg, out_col_next;
    logic signed [15:0] out_row_reg, out_row_next;
    logic [1:0]         out_tool_reg, out_tool_next;

    // Frame memory ports.
    logic [7:0]         frame_mem [FRAME_SIZE*FRAME_SIZE];
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [7:0]         wr_data;
    logic               rd_en;

    // Grey conversion unit.
    logic               grey_start;
    grey_stat_t         grey_stat;

    // Command decode.
    logic               accept;
    logic [1:0]         op;
    logic [5:0]         opnd;
    logic signed [16:0] sum_x, sum_y;
    logic signed [15:0] sat_x, sat_y;
    logic signed [15:0] acc_target;
    logic [CNT_W-1:0]   col_inc, row_inc;

    scr_grey_unit u_grey (
        .clk   (clk),
        .rst_n (rst_n),
        .start (grey_start),
        .rgba  (acc_reg),
        .stat  (grey_stat)
    );

    assign accept = req.valid && req.ready;
    assign op     = req.code_byte[7:6];
    assign opnd   = req.code_byte[5:0];

    // Saturating target updates and the unsigned target load.
    always_comb
    begin
        sum_x = {tx_reg[15], tx_reg} + {{11{opnd[5]}}, opnd};
        sum_y = {ty_reg[15], ty_reg} + {{11{opnd[5]}}, opnd};
        if (sum_x[16] != sum_x[15])
            sat_x = sum_x[16] ? 16'sh8000 : 16'sh7FFF;
        else
            sat_x = sum_x[15:0];
        if (sum_y[16] != sum_y[15])
            sat_y = sum_y[16] ? 16'sh8000 : 16'sh7FFF;
        else
            sat_y = sum_y[15:0];
        acc_target = (|acc_reg[31:15]) ? 16'sh7FFF : {1'b0, acc_reg[14:0]};
        col_inc    = col_reg + CNT_W'(1);
        row_inc    = row_reg + CNT_W'(1);
    end

    // Main sequencer.
    always_comb
    begin
        state_next     = state_reg;
        pen_x_next     = pen_x_reg;
        pen_y_next     = pen_y_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        grey_next      = grey_reg;
        acc_next       = acc_reg;
        tool_next      = tool_reg;
        clr_addr_next  = clr_addr_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        c0_next        = c0_reg;
        r1_next        = r1_reg;
        c1_next        = c1_reg;
        base_next      = base_reg;
        addr_next      = addr_reg;
        rd_row_next    = rd_row_reg;
        rd_col_next    = rd_col_reg;
        rd_ok_next     = rd_ok_reg;
        is_read_next   = is_read_reg;
        rd_addr_next   = rd_addr_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_pix_next   = out_pix_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_tool_next  = out_tool_reg;
        wr_en          = 1'b0;
        wr_addr        = addr_reg;
        wr_data        = grey_reg;
        rd_en          = 1'b0;
        grey_start     = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = '0;
                if (clr_addr_reg == LAST_ADDR)
                    state_next = ST_IDLE;
                else
                    clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.cmd)
                    begin
                        // Pixel read: hold the coordinates and range check.
                        is_read_next = 1'b1;
                        rd_row_next  = req.read_row;
                        rd_col_next  = req.read_col;
                        rd_ok_next   = ({1'b0, req.read_col} < FS_9) &&
                                       ({1'b0, req.read_row} < FS_9);
                        state_next   = ST_RADDR;
                    end
                    else
                    begin
                        is_read_next = 1'b0;
                        state_next   = ST_DELIVER;
                        unique case (op)
                            OP_DX:
                            begin
                                tx_next = sat_x;
                            end
                            OP_DY:
                            begin
                                ty_next = sat_y;
                                if (tool_reg == TOOL_BLOCK)
                                    state_next = ST_FSETUP;
                                else
                                begin
                                    pen_x_next = tx_reg;
                                    pen_y_next = sat_y;
                                end
                            end
                            OP_TOOL:
                            begin
                                acc_next = '0;
                                unique case (opnd)
                                    TSEL_NONE:    tool_next = TOOL_NONE;
                                    TSEL_LINE:    tool_next = TOOL_LINE;
                                    TSEL_BLOCK:   tool_next = TOOL_BLOCK;
                                    TSEL_COLOUR:
                                    begin
                                        grey_start = 1'b1;
                                        state_next = ST_GREY;
                                    end
                                    TSEL_TARGETX: tx_next = acc_target;
                                    TSEL_TARGETY: ty_next = acc_target;
                                    default:      acc_next = '0;
                                endcase
                            end
                            OP_DATA:
                            begin
                                acc_next = {acc_reg[25:0], opnd};
                            end
                            default:
                            begin
                                state_next = ST_DELIVER;
                            end
                        endcase
                    end
                end
            end
            ST_GREY:
            begin
                if (grey_stat.done)
                begin
                    grey_next  = grey_stat.value;
                    state_next = ST_DELIVER;
                end
            end
            ST_FSETUP:
            begin
                // Clip the block from the pen to the target against the frame.
                row_next   = clamp_frame(pen_y_reg);
                col_next   = clamp_frame(pen_x_reg);
                c0_next    = clamp_frame(pen_x_reg);
                r1_next    = clamp_frame(ty_reg);
                c1_next    = clamp_frame(tx_reg);
                state_next = ST_FBASE;
            end
            ST_FBASE:
            begin
                if ((row_reg >= r1_reg) || (c0_reg >= c1_reg))
                begin
                    // Empty block: the colour is still used up.
                    grey_next  = '0;
                    pen_x_next = tx_reg;
                    pen_y_next = ty_reg;
                    state_next = ST_DELIVER;
                end
                else
                begin
                    base_next  = ADDR_W'(row_reg) * FS_A;
                    addr_next  = ADDR_W'(row_reg) * FS_A + ADDR_W'(c0_reg);
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                // One pixel is written per cycle, row by row.
                wr_en = 1'b1;
                if (col_inc < c1_reg)
                begin
                    col_next  = col_inc;
                    addr_next = addr_reg + ADDR_W'(1);
                end
                else if (row_inc < r1_reg)
                begin
                    row_next  = row_inc;
                    col_next  = c0_reg;
                    base_next = base_reg + FS_A;
                    addr_next = base_reg + FS_A + ADDR_W'(c0_reg);
                end
                else
                begin
                    grey_next  = '0;
                    pen_x_next = tx_reg;
                    pen_y_next = ty_reg;
                    state_next = ST_DELIVER;
                end
            end
            ST_RADDR:
            begin
                rd_addr_next = ADDR_W'(rd_row_reg) * FS_A + ADDR_W'(rd_col_reg);
                state_next   = ST_RMEM;
            end
            ST_RMEM:
            begin
                rd_en      = 1'b1;
                state_next = ST_DELIVER;
            end
            ST_DELIVER:
            begin
                // Load the output register once it is free.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_pix_next   = (is_read_reg && rd_ok_reg) ? rd_data_reg : 8'd0;
                    out_col_next   = pen_x_reg;
                    out_row_next   = pen_y_reg;
                    out_tool_next  = tool_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            tx_reg        <= '0;
            ty_reg        <= '0;
            grey_reg      <= '0;
            acc_reg       <= '0;
            tool_reg      <= TOOL_LINE;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pen_x_reg     <= pen_x_next;
            pen_y_reg     <= pen_y_next;
            tx_reg        <= tx_next;
            ty_reg        <= ty_next;
            grey_reg      <= grey_next;
            acc_reg       <= acc_next;
            tool_reg      <= tool_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        col_reg      <= col_next;
        c0_reg       <= c0_next;
        r1_reg       <= r1_next;
        c1_reg       <= c1_next;
        base_reg     <= base_next;
        addr_reg     <= addr_next;
        rd_row_reg   <= rd_row_next;
        rd_col_reg   <= rd_col_next;
        rd_ok_reg    <= rd_ok_next;
        is_read_reg  <= is_read_next;
        rd_addr_reg  <= rd_addr_next;
        out_pix_reg  <= out_pix_next;
        out_col_reg  <= out_col_next;
        out_row_reg  <= out_row_next;
        out_tool_reg <= out_tool_next;
    end

    // Frame memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            frame_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= frame_mem[rd_addr_reg];
    end

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.pixel_value = out_pix_reg;
    assign rsp.pen_col     = out_col_reg;
    assign rsp.pen_row     = out_row_reg;
    assign rsp.active_tool = out_tool_reg;

endmodule

[hdl/scr_grey_unit.sv]
// ============================================================================
// scr_grey_unit: RGBA to grey conversion
// One shared multiplier is used four times over a six-step sequence: three
// weighted products are summed with the rounding term, then the sum is scaled
// by a reciprocal.
// ============================================================================
module scr_grey_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        rgba,
    output scr_pkg::grey_stat_t stat
);
    import scr_pkg::*;

    localparam logic [2:0] GS_IDLE = 3'd0;
    localparam logic [2:0] GS_MULR = 3'd1;
    localparam logic [2:0] GS_MULG = 3'd2;
    localparam logic [2:0] GS_MULB = 3'd3;
    localparam logic [2:0] GS_SUM  = 3'd4;
    localparam logic [2:0] GS_DIV  = 3'd5;
    localparam logic [2:0] GS_OUT  = 3'd6;

    logic [2:0]        step_reg, step_next;
    logic [23:0]       rgb_reg, rgb_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [7:0]        value_reg, value_next;
    logic              done_reg, done_next;
    logic [SUM_W-1:0]  mul_a;
    logic [RECIP_W-1:0] mul_b;

    // Operand selection for the shared multiplier and step sequencing.
    always_comb
    begin
        step_next  = step_reg;
        rgb_next   = rgb_reg;
        sum_next   = sum_reg;
        value_next = value_reg;
        done_next  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (step_reg)
            GS_IDLE:
            begin
                if (start)
                begin
                    rgb_next  = rgba[31:8];
                    sum_next  = GREY_ROUND;
                    step_next = GS_MULR;
                end
            end
            GS_MULR:
            begin
                mul_a     = SUM_W'(rgb_reg[23:16]);
                mul_b     = WEIGHT_R;
                step_next = GS_MULG;
            end
            GS_MULG:
            begin
                sum_next  = sum_reg + prod_reg[SUM_W-1:0];
                mul_a     = SUM_W'(rgb_reg[15:8]);
                mul_b     = WEIGHT_G;
                step_next = GS_MULB;
            end
            GS_MULB:
            begin
                sum_next  = sum_reg + prod_reg[SUM_W-1:0];
                mul_a     = SUM_W'(rgb_reg[7:0]);
                mul_b     = WEIGHT_B;
                step_next = GS_SUM;
            end
            GS_SUM:
            begin
                sum_next  = sum_reg + prod_reg[SUM_W-1:0];
                step_next = GS_DIV;
            end
            GS_DIV:
            begin
                mul_a     = sum_reg;
                mul_b     = GREY_RECIP;
                step_next = GS_OUT;
            end
            GS_OUT:
            begin
                value_next = prod_reg[GREY_SHIFT+7:GREY_SHIFT];
                done_next  = 1'b1;
                step_next  = GS_IDLE;
            end
            default:
            begin
                step_next = GS_IDLE;
            end
        endcase
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Sequencer state and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= GS_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rgb_reg   <= rgb_next;
        sum_reg   <= sum_next;
        prod_reg  <= prod_next;
        value_reg <= value_next;
    end

    assign stat.done  = done_reg;
    assign stat.value = value_reg;

endmodule

[hdl/scr_checker.sv]
// ============================================================================
// scr_checker: port-level checks for the sketch command rasterizer
// Watches both channels and flags sequencing slips seen at the ports.
// ============================================================================
module scr_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [7:0]        rsp_pixel_value,
    input logic signed [15:0] rsp_pen_col,
    input logic signed [15:0] rsp_pen_row,
    input logic [1:0]        rsp_active_tool
);
    import scr_pkg::*;

    // A stalled result stays in place.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_value) &&
        $stable(rsp_pen_col) && $stable(rsp_pen_row) && $stable(rsp_active_tool))
        else $error("response changed while stalled");

    // Only one transaction is in work: ready drops after each acceptance.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

    // The reported tool is always a real tool.
    a_tool_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_active_tool == TOOL_NONE) ||
                      (rsp_active_tool == TOOL_LINE) ||
                      (rsp_active_tool == TOOL_BLOCK))
        else $error("invalid tool code on response");

    // A fresh result only appears while a transaction is in work.
    a_rsp_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("response without a transaction in work");

endmodule

bind sketch_command_rasterizer scr_checker u_scr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_pixel_value (rsp.pixel_value),
    .rsp_pen_col     (rsp.pen_col),
    .rsp_pen_row     (rsp.pen_row),
    .rsp_active_tool (rsp.active_tool)
);

[test/sketch_raster_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// sketch_raster_checker: response checker for the sketch command rasterizer
// Watches the request and response channels, keeps its own copy of the pen,
// targets, colour, accumulator, tool and frame, predicts one response per
// request transaction and compares it field by field with the block's output.
// ============================================================================
module sketch_raster_checker #(
    parameter int FRAME_SIZE = 200
) (
    input  logic clk,
    input  logic rst_n,
    scr_req_if   req,
    scr_rsp_if   rsp,
    output int   mismatch_count,
    output int   pending_results,
    output int   pixel_reads,
    output int   block_fills,
    output int   pixels_painted
);

    import scr_pkg::*;

    // One predicted response.
    typedef struct packed {
        logic [7:0]         pixel;
        logic signed [15:0] col;
        logic signed [15:0] row;
        logic [1:0]         tool;
    } raster_reply_t;

    // Predicted drawing state.
    int          pen_x;
    int          pen_y;
    int          aim_x;
    int          aim_y;
    logic [7:0]  grey_level;
    logic [31:0] shift_acc;
    logic [1:0]  tool_mode;
    logic [7:0]  canvas [FRAME_SIZE * FRAME_SIZE];

    raster_reply_t awaited_replies [$];

    int mismatches;
    int reads;
    int fills;
    int painted;

    // Clamp a coordinate to the signed 16-bit range.
    function automatic int sat_word(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // The accumulator is taken as unsigned and clamps at the top.
    function automatic int target_from_acc(input logic [31:0] acc);
        if (acc > 32'd32767)
            return 32767;
        return int'(acc);
    endfunction

    // Luma of the RGB bytes, rounded to nearest; alpha is ignored.
    function automatic logic [7:0] grey_from_rgba(input logic [31:0] rgba);
        int unsigned weighted;
        weighted = 299 * rgba[31:24] + 587 * rgba[23:16] + 114 * rgba[15:8] + 500;
        return 8'(weighted / 1000);
    endfunction

    task automatic reset_model();
        pen_x = 0;
        pen_y = 0;
        aim_x = 0;
        aim_y = 0;
        grey_level = '0;
        shift_acc = '0;
        tool_mode = TOOL_LINE;
        awaited_replies.delete();
        foreach (canvas[i])
            canvas[i] = '0;
        mismatches = 0;
        reads = 0;
        fills = 0;
        painted = 0;
    endtask

    // Fill from the pen up to (not including) the target, clipped to the frame.
    task automatic paint_block();
        int r_lo;
        int r_hi;
        int c_lo;
        int c_hi;
        r_lo = (pen_y < 0) ? 0 : pen_y;
        r_hi = (aim_y > FRAME_SIZE) ? FRAME_SIZE : aim_y;
        c_lo = (pen_x < 0) ? 0 : pen_x;
        c_hi = (aim_x > FRAME_SIZE) ? FRAME_SIZE : aim_x;
        for (int r = r_lo; r < r_hi; r++)
        begin
            for (int c = c_lo; c < c_hi; c++)
            begin
                canvas[r * FRAME_SIZE + c] = grey_level;
                painted++;
            end
        end
        fills++;
        grey_level = '0;
    endtask

    // Advance the drawing state by one request and queue the response it owes.
    task automatic apply_sketch_item(input logic rd, input logic [7:0] code,
                                     input logic [7:0] col, input logic [7:0] row);
        raster_reply_t reply;
        logic [5:0]    arg_bits;
        int            arg;
        reply.pixel = '0;
        if (rd)
        begin
            reads++;
            if (col < FRAME_SIZE && row < FRAME_SIZE)
                reply.pixel = canvas[int'(row) * FRAME_SIZE + int'(col)];
        end
        else
        begin
            arg_bits = code[5:0];
            arg = int'($signed(arg_bits));
            case (code[7:6])
                OP_DX:
                begin
                    aim_x = sat_word(aim_x + arg);
                end
                OP_DY:
                begin
                    aim_y = sat_word(aim_y + arg);
                    if (tool_mode == TOOL_BLOCK)
                        paint_block();
                    pen_x = aim_x;
                    pen_y = aim_y;
                end
                OP_TOOL:
                begin
                    case (arg_bits)
                        TSEL_NONE, TSEL_LINE, TSEL_BLOCK: tool_mode = arg_bits[1:0];
                        TSEL_COLOUR:  grey_level = grey_from_rgba(shift_acc);
                        TSEL_TARGETX: aim_x = target_from_acc(shift_acc);
                        TSEL_TARGETY: aim_y = target_from_acc(shift_acc);
                        default: ;
                    endcase
                    shift_acc = '0;
                end
                OP_DATA:
                begin
                    shift_acc = {shift_acc[25:0], arg_bits};
                end
                default: ;
            endcase
        end
        reply.col = pen_x[15:0];
        reply.row = pen_y[15:0];
        reply.tool = tool_mode;
        awaited_replies.push_back(reply);
    endtask

    // Compare one response transaction with the oldest prediction.
    task automatic check_reply();
        raster_reply_t want;
        if (awaited_replies.size() == 0)
        begin
            $error("response transaction with no request outstanding");
            mismatches++;
        end
        else
        begin
            want = awaited_replies.pop_front();
            if (rsp.pixel_value !== want.pixel)
            begin
                $error("pixel_value: expected %0d, actual %0d", want.pixel, rsp.pixel_value);
                mismatches++;
            end
            if (rsp.pen_col !== want.col)
            begin
                $error("pen_col: expected %0d, actual %0d", want.col, rsp.pen_col);
                mismatches++;
            end
            if (rsp.pen_row !== want.row)
            begin
                $error("pen_row: expected %0d, actual %0d", want.row, rsp.pen_row);
                mismatches++;
            end
            if (rsp.active_tool !== want.tool)
            begin
                $error("active_tool: expected %0d, actual %0d", want.tool, rsp.active_tool);
                mismatches++;
            end
        end
    endtask

    // Responses are checked before the request of the same edge is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_model();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                check_reply();
            if (req.valid && req.ready)
                apply_sketch_item(req.cmd, req.code_byte, req.read_col, req.read_row);
        end
        mismatch_count <= mismatches;
        pending_results <= awaited_replies.size();
        pixel_reads <= reads;
        block_fills <= fills;
        pixels_painted <= painted;
    end

endmodule

[test/tb_sketch_command_rasterizer.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_sketch_command_rasterizer: testbench of the sketch command rasterizer
// Drives command and pixel read transactions with random pacing on both
// channels: a short directed opening, then block drawing sequences, pixel
// probes, command noise and a walk of the x target to its lower limit.
// A separate checker predicts and compares every response.
// ============================================================================
module tb_sketch_command_rasterizer;

    import scr_pkg::*;

    localparam int FRAME_SIZE   = 200;
    localparam int RANDOM_ITEMS = 1750;
    localparam int QUIET_LIMIT  = 300000;
    localparam int SETTLE_CYCLES = 20;
    localparam int LONG_HOLD    = 600;
    localparam int WALK_STEPS   = 1030;

    logic clk = 1'b0;
    logic rst_n;

    scr_req_if req_ch ();
    scr_rsp_if rsp_ch ();

    int mismatch_count;
    int pending_results;
    int pixel_reads;
    int block_fills;
    int pixels_painted;

    int items_sent;
    int hold_ticket;
    int big_fills;
    bit gapless;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sketch_command_rasterizer #(
        .FRAME_SIZE(FRAME_SIZE)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    sketch_raster_checker #(
        .FRAME_SIZE(FRAME_SIZE)
    ) raster_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .mismatch_count (mismatch_count),
        .pending_results(pending_results),
        .pixel_reads    (pixel_reads),
        .block_fills    (block_fills),
        .pixels_painted (pixels_painted)
    );

    function automatic logic [7:0] sketch_byte(input logic [1:0] op, input logic [5:0] field);
        return {op, field};
    endfunction

    function automatic logic [7:0] byte_clip(input int v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return 8'(v);
    endfunction

    // Coordinates mostly near the frame origin, some at the far edge or beyond.
    function automatic int pick_coord();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70)
            return $urandom_range(0, 60);
        if (p < 90)
            return $urandom_range(FRAME_SIZE - 30, FRAME_SIZE - 1);
        return $urandom_range(FRAME_SIZE, FRAME_SIZE + 40);
    endfunction

    // Offer one request and hold it until the block takes it, then maybe idle.
    task automatic push_item(input logic rd, input logic [7:0] code,
                             input logic [7:0] col, input logic [7:0] row);
        int p;
        int gap;
        req_ch.valid <= 1'b1;
        req_ch.cmd <= rd;
        req_ch.code_byte <= code;
        req_ch.read_col <= col;
        req_ch.read_row <= row;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        items_sent++;
        if (!gapless)
        begin
            p = $urandom_range(0, 99);
            if (p < 60)
                gap = 0;
            else if (p < 90)
                gap = $urandom_range(1, 3);
            else if (p < 98)
                gap = $urandom_range(4, 15);
            else
                gap = $urandom_range(30, 100);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_code(input logic [7:0] code);
        push_item(1'b0, code, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic send_read(input logic [7:0] col, input logic [7:0] row);
        push_item(1'b1, 8'($urandom_range(0, 255)), col, row);
    endtask

    // Shift a value into the accumulator, most significant chunk first.
    task automatic shift_in(input logic [35:0] v, input int chunks);
        for (int i = chunks - 1; i >= 0; i--)
            send_code(sketch_byte(OP_DATA, v[6 * i +: 6]));
    endtask

    task automatic load_target(input logic [5:0] sel, input int value);
        shift_in(36'(value), 3);
        send_code(sketch_byte(OP_TOOL, sel));
    endtask

    // Colour from an RGBA word, with the extremes and pure channels now and then.
    task automatic set_colour();
        logic [31:0] rgba;
        int          p;
        p = $urandom_range(0, 9);
        if (p == 0)
            rgba = 32'hFFFF_FFFF;
        else if (p == 1)
            rgba = 32'h0000_0000;
        else if (p == 2)
            rgba = 32'hFF << (8 * $urandom_range(0, 3));
        else
            rgba = $urandom;
        shift_in({4'($urandom_range(0, 15)), rgba}, 6);
        send_code(sketch_byte(OP_TOOL, TSEL_COLOUR));
    endtask

    // Wait until every response owed has come back.
    task automatic wait_for_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    // Park the pen, pick a colour and fill a block, then probe it.
    task automatic draw_block();
        int x0;
        int y0;
        int x1;
        int y1;
        int nx;
        int ny;
        int w;
        int h;
        int lo_c;
        int lo_r;
        bit wide;
        send_code(sketch_byte(OP_TOOL, ($urandom_range(0, 1) == 0) ? TSEL_NONE : TSEL_LINE));
        wide = (big_fills < 3) && ($urandom_range(0, 39) == 0);
        if (wide)
        begin
            x0 = 0;
            y0 = 0;
            big_fills++;
        end
        else
        begin
            x0 = pick_coord();
            y0 = pick_coord();
        end
        nx = ($urandom_range(0, 3) == 0) ? -int'($urandom_range(1, 12)) : 0;
        ny = ($urandom_range(0, 3) == 0) ? -int'($urandom_range(1, 12)) : 0;
        load_target(TSEL_TARGETX, x0);
        load_target(TSEL_TARGETY, y0);
        if (nx != 0)
            send_code(sketch_byte(OP_DX, 6'(nx)));
        send_code(sketch_byte(OP_DY, 6'(ny)));
        set_colour();

        // Some sequences break off before the block is drawn.
        if ($urandom_range(0, 9) == 0)
            return;

        if (wide)
        begin
            w = FRAME_SIZE + $urandom_range(0, 30);
            h = FRAME_SIZE + $urandom_range(0, 30);
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            w = ($urandom_range(0, 1) == 0) ? -int'($urandom_range(0, 6)) : $urandom_range(1, 8);
            h = -int'($urandom_range(0, 6));
        end
        else
        begin
            w = $urandom_range(1, 24);
            h = $urandom_range(1, 24);
        end
        x1 = (x0 + w < 0) ? 0 : x0 + w;
        y1 = (y0 + h < 0) ? 0 : y0 + h;
        load_target(TSEL_TARGETX, x1);
        load_target(TSEL_TARGETY, y1);
        send_code(sketch_byte(OP_TOOL, TSEL_BLOCK));
        send_code(sketch_byte(OP_DY, 6'(int'($urandom_range(0, 4)) - 2)));

        // Probe in and around the block.
        lo_c = (x0 + nx < 0) ? 0 : x0 + nx;
        lo_r = (y0 + ny < 0) ? 0 : y0 + ny;
        repeat ($urandom_range(1, 4))
            send_read(byte_clip($urandom_range(lo_c, x1 + 1)),
                      byte_clip($urandom_range(lo_r, y1 + 1)));

        // The colour was cleared by the fill, so a follow-up block paints zero.
        if ($urandom_range(0, 3) == 0)
        begin
            load_target(TSEL_TARGETX, x1 + $urandom_range(1, 6));
            send_code(sketch_byte(OP_DY, 6'($urandom_range(1, 4))));
            send_read(byte_clip(x1), byte_clip(y1));
        end
    endtask

    task automatic probe_pixels();
        int p;
        repeat ($urandom_range(1, 8))
        begin
            p = $urandom_range(0, 99);
            if (p < 50)
                send_read(8'($urandom_range(0, 63)), 8'($urandom_range(0, 63)));
            else if (p < 80)
                send_read(8'($urandom_range(0, FRAME_SIZE - 1)),
                          8'($urandom_range(0, FRAME_SIZE - 1)));
            else
                send_read(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
    endtask

    // Random command bytes with no block tool, so nothing large gets filled.
    task automatic scramble();
        logic [7:0] code;
        logic [5:0] sel;
        send_code(sketch_byte(OP_TOOL, ($urandom_range(0, 1) == 0) ? TSEL_NONE : TSEL_LINE));
        if ($urandom_range(0, 4) == 0)
        begin
            // Full-width accumulator loads reach the saturating target cases.
            shift_in({4'($urandom_range(0, 15)), 32'($urandom)}, 6);
            case ($urandom_range(0, 2))
                0: sel = TSEL_TARGETX;
                1: sel = TSEL_TARGETY;
                default: sel = TSEL_COLOUR;
            endcase
            send_code(sketch_byte(OP_TOOL, sel));
        end
        repeat ($urandom_range(1, 6))
        begin
            code = 8'($urandom_range(0, 255));
            if (code[7:6] == OP_TOOL && code[5:0] == TSEL_BLOCK)
                code[5:0] = TSEL_LINE;
            send_code(code);
        end
    endtask

    // Walk the x target down to the lowest coordinate and past it, then move the pen.
    task automatic walk_to_floor();
        send_code(sketch_byte(OP_TOOL, TSEL_NONE));
        load_target(TSEL_TARGETX, 0);
        repeat (WALK_STEPS)
            send_code(sketch_byte(OP_DX, 6'h20));
        send_code(sketch_byte(OP_DY, 6'h20));
    endtask

    task automatic run_directed();
        // A fresh frame reads zero everywhere; reads off the frame give zero.
        send_read(8'd0, 8'd0);
        send_read(8'(FRAME_SIZE - 1), 8'(FRAME_SIZE - 1));
        send_read(8'd255, 8'(FRAME_SIZE));
        send_read(8'd0, 8'd255);
        // An all-ones accumulator clamps the target load; DX at the top clamps.
        repeat (6)
            send_code(sketch_byte(OP_DATA, 6'h3F));
        send_code(sketch_byte(OP_TOOL, TSEL_TARGETX));
        send_code(sketch_byte(OP_DX, 6'h1F));
        send_code(sketch_byte(OP_DY, 6'h00));
        // Unused tool codes only clear the accumulator.
        send_code(sketch_byte(OP_DATA, 6'h2A));
        send_code(sketch_byte(OP_TOOL, 6'h06));
        send_code(sketch_byte(OP_TOOL, TSEL_TARGETY));
        send_code(sketch_byte(OP_DATA, 6'h15));
        send_code(sketch_byte(OP_TOOL, 6'h3F));
        send_code(sketch_byte(OP_TOOL, TSEL_COLOUR));
        // Most negative operand, every tool, then a reversed block.
        send_code(sketch_byte(OP_DX, 6'h20));
        send_code(sketch_byte(OP_TOOL, TSEL_NONE));
        send_code(sketch_byte(OP_TOOL, TSEL_LINE));
        send_code(sketch_byte(OP_TOOL, TSEL_BLOCK));
        send_code(sketch_byte(OP_DY, 6'h20));
        send_read(8'd5, 8'd5);
    endtask

    task automatic run_random();
        int first;
        int p;
        bit walked;
        first = items_sent;
        walked = 1'b0;

        // Stall the response side while requests keep coming.
        hold_ticket++;
        gapless = 1'b1;
        scramble();
        probe_pixels();
        gapless = 1'b0;

        while (items_sent - first < RANDOM_ITEMS)
        begin
            if (!walked && items_sent - first > RANDOM_ITEMS / 3)
            begin
                hold_ticket++;
                walk_to_floor();
                walked = 1'b1;
            end
            gapless = ($urandom_range(0, 9) == 0);
            p = $urandom_range(0, 99);
            if (p < 40)
                draw_block();
            else if (p < 65)
                probe_pixels();
            else if (p < 92)
                scramble();
            else
                wait_for_idle();
        end
        gapless = 1'b0;
    endtask

    // Response side: ready stretches, short and long hold-offs, and toggling.
    initial
    begin : response_pacing
        int hold_seen;
        int p;
        hold_seen = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_ticket != hold_seen)
            begin
                hold_seen = hold_ticket;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                p = $urandom_range(0, 99);
                if (p < 45)
                begin
                    rsp_ch.ready <= 1'b1;
                    repeat ($urandom_range(1, 40)) @(posedge clk);
                end
                else if (p < 80)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end
                else if (p < 95)
                begin
                    repeat ($urandom_range(1, 20))
                    begin
                        rsp_ch.ready <= 1'($urandom_range(0, 1));
                        @(posedge clk);
                    end
                end
                else
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat ($urandom_range(20, 150)) @(posedge clk);
                end
            end
        end
    end

    // Watchdog: too long with no transaction on either channel ends the run.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Watchdog expired after %0d idle cycles", QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        items_sent = 0;
        hold_ticket = 0;
        big_fills = 0;
        gapless = 1'b0;
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.cmd <= 1'b0;
        req_ch.code_byte <= '0;
        req_ch.read_col <= '0;
        req_ch.read_row <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_for_idle();
        run_random();
        wait_for_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d transactions: %0d pixel reads, %0d block fills over %0d pixels",
                 items_sent, pixel_reads, block_fills, pixels_painted);
        $display("Mismatches: %0d, responses still owed: %0d", mismatch_count, pending_results);
        if (mismatch_count == 0 && pending_results == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
